FILE: rtl/assert_macros.svh
// Assertion macros shared by the modules of the write-register framer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MWF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mwf_pkg.sv
// Package for the Modbus RTU write-single-register framer.
// Holds frame constants, register indexes, shared types and the CRC-16 byte step.
`timescale 1ns / 1ps

package mwf_pkg;

  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;

  localparam logic [7:0]  RST_SLAVE_ADDRESS    = 8'h01;
  localparam logic [15:0] RST_REGISTER_ADDRESS = 16'd30;
  localparam logic [15:0] RST_VALUE_LIMIT      = 16'd2000;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SLAVE_ADDRESS    = 2'd0;
  localparam logic [1:0] CFG_REGISTER_ADDRESS = 2'd1;
  localparam logic [1:0] CFG_VALUE_LIMIT      = 2'd2;

  // Byte positions within the eight-byte frame.
  localparam logic [2:0] POS_SLAVE    = 3'd0;
  localparam logic [2:0] POS_FUNC     = 3'd1;
  localparam logic [2:0] POS_REG_HI   = 3'd2;
  localparam logic [2:0] POS_REG_LO   = 3'd3;
  localparam logic [2:0] POS_VALUE_HI = 3'd4;
  localparam logic [2:0] POS_VALUE_LO = 3'd5;
  localparam logic [2:0] POS_CRC_LO   = 3'd6;
  localparam logic [2:0] POS_CRC_HI   = 3'd7;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [15:0] register_address;
    logic [15:0] value_limit;
  } mwf_cfg_t;

  typedef struct packed {
    logic frame_valid;  // a frame is being serialised
    logic byte_load;    // a frame byte moves into the output register
    logic last_load;    // that byte is the CRC high byte
  } mwf_status_t;

  // One byte of CRC-16/MODBUS, least significant bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/mwf_cfg_regs.sv
// Configuration registers of the write-register framer.
// Depends on mwf_pkg for register indexes, reset values and the config struct.
`timescale 1ns / 1ps

module mwf_cfg_regs import mwf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output mwf_cfg_t    cfg
);

  mwf_cfg_t cfg_r;
  mwf_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SLAVE_ADDRESS:    cfg_nxt.slave_address    = cfg_wdata[7:0];
        CFG_REGISTER_ADDRESS: cfg_nxt.register_address = cfg_wdata;
        CFG_VALUE_LIMIT:      cfg_nxt.value_limit      = cfg_wdata;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave_address    <= RST_SLAVE_ADDRESS;
      cfg_r.register_address <= RST_REGISTER_ADDRESS;
      cfg_r.value_limit      <= RST_VALUE_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/mwf_clamp.sv
// Saturation of the signed set value to the range zero to the configured limit.
// Depends on nothing but the standard types.
`timescale 1ns / 1ps

module mwf_clamp (
  input  logic signed [15:0] set_value,
  input  logic        [15:0] value_limit,
  output logic        [15:0] value
);

  logic [15:0] raw;

  assign raw = $unsigned(set_value);

  always_comb begin
    if (set_value[15]) begin
      value = 16'h0000;
    end else if (raw > value_limit) begin
      value = value_limit;
    end else begin
      value = raw;
    end
  end

endmodule

FILE: rtl/mwf_serializer.sv
// Frame register and byte serialiser with a running CRC-16 and output register.
// Depends on mwf_pkg for frame constants, the config struct and the CRC step.
`timescale 1ns / 1ps

module mwf_serializer import mwf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  mwf_cfg_t    cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte,
  output logic        out_frame_last,
  output mwf_status_t status
);

  logic        frame_valid_r, frame_valid_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [15:0] value_r, value_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;

  logic       out_ready;
  logic       byte_load;
  logic       last_load;
  logic       accept;
  logic [7:0] cur_byte;

  assign out_ready = !out_valid_r || !out_stall;
  assign byte_load = frame_valid_r && out_ready;
  assign last_load = byte_load && (pos_r == POS_CRC_HI);
  // A new request enters as the last byte of the current frame leaves.
  assign in_stall  = frame_valid_r && !last_load;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    case (pos_r)
      POS_SLAVE:    cur_byte = cfg.slave_address;
      POS_FUNC:     cur_byte = FUNC_WRITE_SINGLE;
      POS_REG_HI:   cur_byte = cfg.register_address[15:8];
      POS_REG_LO:   cur_byte = cfg.register_address[7:0];
      POS_VALUE_HI: cur_byte = value_r[15:8];
      POS_VALUE_LO: cur_byte = value_r[7:0];
      POS_CRC_LO:   cur_byte = crc_r[7:0];
      POS_CRC_HI:   cur_byte = crc_r[15:8];
      default:      cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    frame_valid_nxt = frame_valid_r;
    pos_nxt         = pos_r;
    value_nxt       = value_r;
    crc_nxt         = crc_r;
    if (accept) begin
      frame_valid_nxt = 1'b1;
      pos_nxt         = POS_SLAVE;
      value_nxt       = value;
      crc_nxt         = CRC_INIT;
    end else if (byte_load) begin
      pos_nxt = pos_r + 3'd1;
      if (last_load) begin
        frame_valid_nxt = 1'b0;
      end
      // The CRC covers the six body bytes; it is complete once they have passed.
      if (pos_r != POS_CRC_LO && pos_r != POS_CRC_HI) begin
        crc_nxt = crc_byte(crc_r, cur_byte);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_ready) begin
      out_valid_nxt = byte_load;
      if (byte_load) begin
        out_byte_nxt = cur_byte;
        out_last_nxt = (pos_r == POS_CRC_HI);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= 1'b0;
      pos_r         <= POS_SLAVE;
      out_valid_r   <= 1'b0;
    end else begin
      frame_valid_r <= frame_valid_nxt;
      pos_r         <= pos_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    crc_r      <= crc_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_last = out_last_r;

  assign status.frame_valid = frame_valid_r;
  assign status.byte_load   = byte_load;
  assign status.last_load   = last_load;

endmodule

FILE: rtl/modbus_write_register_framer_unit.sv
// A request is accepted into the frame register; each frame byte then moves into the output
// register, one frame byte per cycle while the output does not stall; the next request is
// taken in the cycle the CRC high byte leaves the frame register.
// Reset (synchronous, rst_n low): slave address 1, register 30, limit 2000, no frame
// in flight. No clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module modbus_write_register_framer_unit import mwf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_set_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_frame_byte,
  output logic               out_frame_last
);

  mwf_cfg_t    cfg;
  mwf_status_t status;
  logic [15:0] clamped_value;

  mwf_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mwf_clamp u_clamp (
    .set_value   (in_set_value),
    .value_limit (cfg.value_limit),
    .value       (clamped_value)
  );

  mwf_serializer u_serializer (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .value          (clamped_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_frame_last (out_frame_last),
    .status         (status)
  );

  `MWF_ASSERT_NEXT(a_accept_starts_frame, in_valid && !in_stall, status.frame_valid, "no frame")
  `MWF_ASSERT_SAME(a_ready_only_at_end, status.frame_valid && !in_stall, status.last_load, "early")
  `MWF_ASSERT_NEXT(a_byte_presented, status.byte_load, out_valid, "frame byte not presented")
  `MWF_ASSERT_NEXT(a_last_flagged, status.last_load, out_valid && out_frame_last, "last unflagged")

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the Modbus RTU write-single-register framer.
// A directed table and then random requests are driven while a frame predictor
// works out the eight bytes of each frame. Depends on mwf_pkg and the framer RTL.
`timescale 1ns / 1ps

module tb_top import mwf_pkg::*; ();

  // Index with no register behind it; a write to it must change nothing.
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int RANDOM_BLOCKS = 6;
  localparam int BLOCK_REQUESTS = 39;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_REQ,
    ROW_REQ_KNOWN
  } row_kind_t;

  // For ROW_CFG the data field is the write data, otherwise the set value.
  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  index;
    logic [15:0] data;
    logic [15:0] known_value;
  } stim_row_t;

  typedef struct {
    logic [7:0] octet;
    logic       last;
  } frame_byte_t;

  localparam int NUM_ROWS = 25;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_SLAVE_ADDRESS;
  logic [15:0]        cfg_wdata = 16'h0000;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_set_value = 16'sd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_frame_byte;
  logic               out_frame_last;

  // Describes the request currently offered: whether its clamped value is typed in.
  logic               req_known = 1'b0;
  logic [15:0]        req_known_value = 16'h0000;

  logic [7:0]         shadow_slave_address = RST_SLAVE_ADDRESS;
  logic [15:0]        shadow_register_address = RST_REGISTER_ADDRESS;
  logic [15:0]        shadow_value_limit = RST_VALUE_LIMIT;

  frame_byte_t        expected_bytes[$];
  int                 error_count = 0;
  int                 send_idle_pct = 34;
  int                 recv_idle_pct = 85;
  stim_row_t          stim_rows [0:NUM_ROWS-1];

  modbus_write_register_framer_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_set_value   (in_set_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_frame_last (out_frame_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
                                                    input logic [7:0]  octet);
    logic [15:0] acc;
    acc = crc ^ {8'h00, octet};
    repeat (8) begin
      acc = acc[0] ? ({1'b0, acc[15:1]} ^ CRC_POLY) : {1'b0, acc[15:1]};
    end
    return acc;
  endfunction

  function automatic logic [15:0] clamp_set_value(input logic [15:0] raw,
                                                  input logic [15:0] limit);
    if (raw[15]) begin
      return 16'h0000;
    end else if (raw > limit) begin
      return limit;
    end
    return raw;
  endfunction

  task automatic push_expected_frame(input logic [15:0] value);
    logic [7:0]  body [0:5];
    logic [15:0] crc;
    frame_byte_t fb;
    body[0] = shadow_slave_address;
    body[1] = FUNC_WRITE_SINGLE;
    body[2] = shadow_register_address[15:8];
    body[3] = shadow_register_address[7:0];
    body[4] = value[15:8];
    body[5] = value[7:0];
    crc = CRC_INIT;
    for (int k = 0; k < 6; k++) begin
      crc = crc16_modbus_step(crc, body[k]);
      fb.octet = body[k];
      fb.last = 1'b0;
      expected_bytes.push_back(fb);
    end
    fb.octet = crc[7:0];
    fb.last = 1'b0;
    expected_bytes.push_back(fb);
    fb.octet = crc[15:8];
    fb.last = 1'b1;
    expected_bytes.push_back(fb);
  endtask

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t ns: %s", $time, what);
    end
  endtask

  // Checks returned bytes first, then predicts the frame of an accepted request, then
  // tracks register writes, all from values sampled at the rising edge.
  always @(posedge clk) begin
    frame_byte_t exp_byte;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected frame byte %02h last %0b",
                                    out_frame_byte, out_frame_last));
        end else begin
          exp_byte = expected_bytes.pop_front();
          if (out_frame_byte !== exp_byte.octet) begin
            report_mismatch($sformatf("frame byte expected %02h got %02h",
                                      exp_byte.octet, out_frame_byte));
          end
          if (out_frame_last !== exp_byte.last) begin
            report_mismatch($sformatf("frame last expected %0b got %0b (byte %02h)",
                                      exp_byte.last, out_frame_last, exp_byte.octet));
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (req_known) begin
          push_expected_frame(req_known_value);
        end else begin
          push_expected_frame(clamp_set_value(in_set_value, shadow_value_limit));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLAVE_ADDRESS:    shadow_slave_address = cfg_wdata[7:0];
          CFG_REGISTER_ADDRESS: shadow_register_address = cfg_wdata;
          CFG_VALUE_LIMIT:      shadow_value_limit = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Entered and left at a falling edge.
  task automatic send_request(input logic [15:0] value, input logic known,
                              input logic [15:0] known_value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      in_set_value = 16'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_set_value = value;
    req_known = known;
    req_known_value = known_value;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic wait_frames_done();
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_register(input logic [1:0] index, input logic [15:0] data);
    wait_frames_done();
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [15:0] pick_set_value();
    logic [15:0] near;
    near = shadow_value_limit - 16'd2 + 16'($urandom_range(4));
    case ($urandom_range(4))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 4095));
      2: return 16'h8000 | 16'($urandom);
      3: return near;
      default: begin
        case ($urandom_range(3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  task automatic program_random_config();
    logic [15:0] limit;
    case ($urandom_range(4))
      0: limit = 16'h0000;
      1: limit = 16'hFFFF;
      2: limit = 16'($urandom_range(0, 4000));
      default: limit = 16'($urandom);
    endcase
    write_register(CFG_SLAVE_ADDRESS, 16'($urandom));
    write_register(CFG_REGISTER_ADDRESS, 16'($urandom));
    write_register(CFG_VALUE_LIMIT, limit);
    if ($urandom_range(3) == 0) begin
      write_register(CFG_SPARE, 16'($urandom));
    end
  endtask

  initial begin
    stim_rows = '{
      '{ROW_REQ_KNOWN, CFG_SLAVE_ADDRESS,    16'h0000, 16'd0},
      '{ROW_REQ_KNOWN, CFG_SLAVE_ADDRESS,    16'h7FFF, 16'd2000},
      '{ROW_REQ_KNOWN, CFG_SLAVE_ADDRESS,    16'h8000, 16'd0},
      '{ROW_REQ_KNOWN, CFG_SLAVE_ADDRESS,    16'hFFFF, 16'd0},
      '{ROW_REQ_KNOWN, CFG_SLAVE_ADDRESS,    16'd2000, 16'd2000},
      '{ROW_REQ_KNOWN, CFG_SLAVE_ADDRESS,    16'd2001, 16'd2000},
      '{ROW_REQ_KNOWN, CFG_SLAVE_ADDRESS,    16'd1999, 16'd1999},
      '{ROW_REQ,       CFG_SLAVE_ADDRESS,    16'h5555, 16'd0},
      '{ROW_CFG,       CFG_SLAVE_ADDRESS,    16'hABFF, 16'd0},
      '{ROW_CFG,       CFG_REGISTER_ADDRESS, 16'hFFFF, 16'd0},
      '{ROW_CFG,       CFG_VALUE_LIMIT,      16'h0000, 16'd0},
      '{ROW_REQ_KNOWN, CFG_SLAVE_ADDRESS,    16'd1234, 16'd0},
      '{ROW_REQ_KNOWN, CFG_SLAVE_ADDRESS,    16'h7FFF, 16'd0},
      '{ROW_CFG,       CFG_SPARE,            16'hFFFF, 16'd0},
      '{ROW_REQ_KNOWN, CFG_SLAVE_ADDRESS,    16'h0001, 16'd0},
      '{ROW_CFG,       CFG_VALUE_LIMIT,      16'hFFFF, 16'd0},
      '{ROW_REQ_KNOWN, CFG_SLAVE_ADDRESS,    16'h7FFF, 16'h7FFF},
      '{ROW_REQ_KNOWN, CFG_SLAVE_ADDRESS,    16'h0001, 16'h0001},
      '{ROW_REQ_KNOWN, CFG_SLAVE_ADDRESS,    16'hAAAA, 16'd0},
      '{ROW_CFG,       CFG_SLAVE_ADDRESS,    16'h0000, 16'd0},
      '{ROW_CFG,       CFG_REGISTER_ADDRESS, 16'h0000, 16'd0},
      '{ROW_CFG,       CFG_VALUE_LIMIT,      16'h7FFF, 16'd0},
      '{ROW_REQ_KNOWN, CFG_SLAVE_ADDRESS,    16'h7FFF, 16'h7FFF},
      '{ROW_REQ_KNOWN, CFG_SLAVE_ADDRESS,    16'h7FFE, 16'h7FFE},
      '{ROW_REQ,       CFG_SLAVE_ADDRESS,    16'h2AAA, 16'd0}
    };

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // The first rows run against the reset values of the registers.
    foreach (stim_rows[i]) begin
      case (stim_rows[i].kind)
        ROW_CFG: write_register(stim_rows[i].index, stim_rows[i].data);
        ROW_REQ_KNOWN: send_request(stim_rows[i].data, 1'b1, stim_rows[i].known_value);
        default: send_request(stim_rows[i].data, 1'b0, 16'h0000);
      endcase
    end

    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      if (blk == 2) begin
        send_idle_pct = 85;
        recv_idle_pct = 34;
      end else if (blk == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_random_config();
      repeat (BLOCK_REQUESTS) begin
        send_request(pick_set_value(), 1'b0, 16'h0000);
      end
    end

    wait_frames_done();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_bytes.size() != 0) begin
      report_mismatch($sformatf("%0d frame bytes never arrived", expected_bytes.size()));
    end

    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mwf_pkg.sv
rtl/mwf_cfg_regs.sv
rtl/mwf_clamp.sv
rtl/mwf_serializer.sv
rtl/modbus_write_register_framer_unit.sv
dv/tb_top.sv
